@@ rtl/slpv_pkg.sv @@
// Shared types and codes for the sorted-L1 proximal vector unit.
package slpv_pkg;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RANK_KEY,
        ST_RANK_KEYW,
        ST_RANK_SCAN,
        ST_RANK_WR,
        ST_POOL_RD,
        ST_POOL_MAG,
        ST_POOL_SUB,
        ST_POOL_CHK,
        ST_POOL_DIV,
        ST_POOL_FIN,
        ST_FILL_HDR,
        ST_FILL_HDW,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    // Sign codes held per element.
    typedef logic [1:0] sign_t;
    localparam sign_t SIGN_ZERO = 2'b00;
    localparam sign_t SIGN_POS  = 2'b01;
    localparam sign_t SIGN_NEG  = 2'b11;

endpackage

@@ rtl/slpv_div.sv @@
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module slpv_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 7
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    // One restoring step.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    // Control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NUM_W-1];
            quo_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_reg <= '0;
            den_reg <= den;
            cnt_reg <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

@@ rtl/sorted_l1_prox_vector_unit.sv @@
// Sorted-L1 proximal operator: rank sort, pool-adjacent-violators stack, reorder and sign restore.
// A vector of up to MAX_LEN elements loads at one transfer per cycle. The transfer with tlast
// (or the one that fills MAX_LEN entries) starts the computation, during which s_tready is low.
// For n elements the work is a rank sort (one magnitude compare per cycle on a single memory
// read port), pooling (one shared bit-serial divider), a reorder pass that writes each block
// value back, and the emission of the results in load order, which can stall on m_tready,
// with tlast on the last. No memory clearing follows reset.
module sorted_l1_prox_vector_unit #(
    parameter int MAX_LEN    = 64,
    parameter int VALUE_BITS = 32,
    localparam int S_TDATA_W = ((2 * VALUE_BITS - 1 + 7) / 8) * 8,
    localparam int M_TDATA_W = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: coef_value (VALUE_BITS), penalty_value (VALUE_BITS-1), zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: prox_value (VALUE_BITS), zero fill.
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);
    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = IDX_W + 1;
    localparam int VB     = VALUE_BITS;
    localparam int SUM_W  = VALUE_BITS + 7;
    localparam int MEAN_W = VALUE_BITS + 1;

    // Element storage.
    logic [VB-1:0]           mag_mem   [MAX_LEN];
    slpv_pkg::sign_t         sign_mem  [MAX_LEN];
    logic [VB-2:0]           pen_mem   [MAX_LEN];
    logic [IDX_W-1:0]        ord_mem   [MAX_LEN];
    logic [VB-1:0]           res_mem   [MAX_LEN];
    // Block stack storage.
    logic [IDX_W-1:0]        stk_start_mem [MAX_LEN];
    logic [IDX_W-1:0]        stk_end_mem   [MAX_LEN];
    logic signed [SUM_W-1:0] stk_sum_mem   [MAX_LEN];
    logic signed [MEAN_W-1:0] stk_mean_mem [MAX_LEN];

    // Read data registers.
    logic [VB-1:0]            mag_rd_reg;
    slpv_pkg::sign_t          sign_rd_reg;
    logic [VB-2:0]            pen_rd_reg;
    logic [IDX_W-1:0]         ord_rd_reg;
    logic [VB-1:0]            res_rd_reg;
    logic [IDX_W-1:0]         stk_start_rd_reg;
    logic [IDX_W-1:0]         stk_end_rd_reg;
    logic signed [SUM_W-1:0]  stk_sum_rd_reg;
    logic signed [MEAN_W-1:0] stk_mean_rd_reg;

    // Sequencer registers.
    slpv_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] rank_reg, rank_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [VB-1:0]    key_reg, key_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic [CNT_W-1:0] pipe_j_reg, pipe_j_next;
    logic             has_top_reg, has_top_next;
    logic             pop_reg, pop_next;
    logic [IDX_W-1:0] top_start_reg, top_start_next;
    logic signed [SUM_W-1:0]  top_sum_reg, top_sum_next;
    logic signed [MEAN_W-1:0] top_mean_reg, top_mean_next;
    logic [IDX_W-1:0] cur_start_reg, cur_start_next;
    logic signed [SUM_W-1:0]  cur_sum_reg, cur_sum_next;
    logic signed [MEAN_W-1:0] cur_mean_reg, cur_mean_next;
    logic [VB-1:0]    d_reg, d_next;
    logic [IDX_W-1:0] end_reg, end_next;
    logic             m_valid_reg, m_valid_next;
    logic [VB-1:0]    m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    // Memory ports.
    logic             load_we;
    logic [IDX_W-1:0] mag_raddr;
    logic             ord_we;
    logic             res_we;
    logic             stk_we;
    logic [IDX_W-1:0] stk_raddr;
    logic [IDX_W-1:0] stk_wend;
    logic [IDX_W-1:0] idx;

    // Input decode.
    logic [VB-1:0]    coef;
    logic [VB-1:0]    in_mag;
    slpv_pkg::sign_t  in_sign;
    logic             s_xfer;

    // Divider.
    logic                    div_start;
    logic                    div_done;
    logic signed [SUM_W-1:0] merged_sum;
    logic [CNT_W-1:0]        merged_len;
    logic signed [SUM_W-1:0] div_quot;
    logic                    rank_hit;
    logic [VB-1:0]           out_val;

    assign idx      = i_reg[IDX_W-1:0];
    assign coef     = s_tdata[VB-1:0];
    assign in_mag   = coef[VB-1] ? VB'(-coef) : coef;
    assign in_sign  = coef[VB-1] ? slpv_pkg::SIGN_NEG
                                 : ((|coef) ? slpv_pkg::SIGN_POS : slpv_pkg::SIGN_ZERO);
    assign s_tready = (state_reg == slpv_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign load_we  = s_xfer;

    assign merged_sum = top_sum_reg + cur_sum_reg;
    assign merged_len = i_reg - CNT_W'(top_start_reg) + CNT_W'(1);

    // Stable descending order: earlier index wins a tie.
    assign rank_hit = (mag_rd_reg > key_reg) ||
                      ((mag_rd_reg == key_reg) && (pipe_j_reg < i_reg));

    slpv_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (merged_sum),
        .den     (merged_len),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Element memories.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            mag_mem[cnt_reg[IDX_W-1:0]]  <= in_mag;
            sign_mem[cnt_reg[IDX_W-1:0]] <= in_sign;
            pen_mem[cnt_reg[IDX_W-1:0]]  <= s_tdata[2*VB-2:VB];
        end
        if (ord_we) begin
            ord_mem[rank_reg[IDX_W-1:0]] <= idx;
        end
        if (res_we) begin
            res_mem[ord_rd_reg] <= d_reg;
        end
        mag_rd_reg  <= mag_mem[mag_raddr];
        sign_rd_reg <= sign_mem[idx];
        pen_rd_reg  <= pen_mem[idx];
        ord_rd_reg  <= ord_mem[idx];
        res_rd_reg  <= res_mem[idx];
    end

    // Block stack memory.
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_start_mem[depth_reg[IDX_W-1:0]] <= top_start_reg;
            stk_end_mem[depth_reg[IDX_W-1:0]]   <= stk_wend;
            stk_sum_mem[depth_reg[IDX_W-1:0]]   <= top_sum_reg;
            stk_mean_mem[depth_reg[IDX_W-1:0]]  <= top_mean_reg;
        end
        stk_start_rd_reg <= stk_start_mem[stk_raddr];
        stk_end_rd_reg   <= stk_end_mem[stk_raddr];
        stk_sum_rd_reg   <= stk_sum_mem[stk_raddr];
        stk_mean_rd_reg  <= stk_mean_mem[stk_raddr];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= slpv_pkg::ST_IDLE;
            cnt_reg      <= '0;
            depth_reg    <= '0;
            pipe_vld_reg <= 1'b0;
            has_top_reg  <= 1'b0;
            pop_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            depth_reg    <= depth_next;
            pipe_vld_reg <= pipe_vld_next;
            has_top_reg  <= has_top_next;
            pop_reg      <= pop_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        rank_reg      <= rank_next;
        b_reg         <= b_next;
        key_reg       <= key_next;
        pipe_j_reg    <= pipe_j_next;
        top_start_reg <= top_start_next;
        top_sum_reg   <= top_sum_next;
        top_mean_reg  <= top_mean_next;
        cur_start_reg <= cur_start_next;
        cur_sum_reg   <= cur_sum_next;
        cur_mean_reg  <= cur_mean_next;
        d_reg         <= d_next;
        end_reg       <= end_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    // Signed result from the pooled magnitude and the stored sign.
    always_comb begin
        case (sign_rd_reg)
            slpv_pkg::SIGN_POS: out_val = res_rd_reg[VB-1] ? {1'b0, {(VB-1){1'b1}}} : res_rd_reg;
            slpv_pkg::SIGN_NEG: out_val = VB'(-res_rd_reg);
            default:            out_val = '0;
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rank_next      = rank_reg;
        depth_next     = depth_reg;
        b_next         = b_reg;
        key_next       = key_reg;
        pipe_vld_next  = pipe_vld_reg;
        pipe_j_next    = pipe_j_reg;
        has_top_next   = has_top_reg;
        pop_next       = pop_reg;
        top_start_next = top_start_reg;
        top_sum_next   = top_sum_reg;
        top_mean_next  = top_mean_reg;
        cur_start_next = cur_start_reg;
        cur_sum_next   = cur_sum_reg;
        cur_mean_next  = cur_mean_reg;
        d_next         = d_reg;
        end_next       = end_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        mag_raddr      = idx;
        stk_raddr      = b_reg[IDX_W-1:0];
        stk_wend       = cur_start_reg - IDX_W'(1);
        ord_we         = 1'b0;
        res_we         = 1'b0;
        stk_we         = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            // Load one element per transfer.
            slpv_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tlast || cnt_reg == CNT_W'(MAX_LEN - 1)) begin
                        n_next     = cnt_reg + CNT_W'(1);
                        i_next     = '0;
                        state_next = slpv_pkg::ST_RANK_KEY;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            // Rank sort: fetch the key, then scan every element.
            slpv_pkg::ST_RANK_KEY: begin
                state_next = slpv_pkg::ST_RANK_KEYW;
            end
            slpv_pkg::ST_RANK_KEYW: begin
                key_next      = mag_rd_reg;
                j_next        = '0;
                rank_next     = '0;
                pipe_vld_next = 1'b0;
                state_next    = slpv_pkg::ST_RANK_SCAN;
            end
            slpv_pkg::ST_RANK_SCAN: begin
                mag_raddr   = j_reg[IDX_W-1:0];
                pipe_j_next = j_reg;
                if (j_reg < n_reg) begin
                    j_next        = j_reg + CNT_W'(1);
                    pipe_vld_next = 1'b1;
                end else begin
                    pipe_vld_next = 1'b0;
                end
                if (pipe_vld_reg && rank_hit) begin
                    rank_next = rank_reg + CNT_W'(1);
                end
                if (j_reg == n_reg && !pipe_vld_reg) begin
                    state_next = slpv_pkg::ST_RANK_WR;
                end
            end
            slpv_pkg::ST_RANK_WR: begin
                ord_we = 1'b1;
                if (i_reg + CNT_W'(1) == n_reg) begin
                    i_next       = '0;
                    depth_next   = '0;
                    has_top_next = 1'b0;
                    state_next   = slpv_pkg::ST_POOL_RD;
                end else begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = slpv_pkg::ST_RANK_KEY;
                end
            end
            // Pooling: fetch the sorted magnitude and the penalty at the same rank.
            slpv_pkg::ST_POOL_RD: begin
                state_next = slpv_pkg::ST_POOL_MAG;
            end
            slpv_pkg::ST_POOL_MAG: begin
                mag_raddr  = ord_rd_reg;
                state_next = slpv_pkg::ST_POOL_SUB;
            end
            slpv_pkg::ST_POOL_SUB: begin
                cur_sum_next   = SUM_W'(mag_rd_reg) - SUM_W'(pen_rd_reg);
                cur_mean_next  = MEAN_W'(SUM_W'(mag_rd_reg) - SUM_W'(pen_rd_reg));
                cur_start_next = idx;
                state_next     = slpv_pkg::ST_POOL_CHK;
            end
            // Merge with the block below while it does not exceed this one.
            slpv_pkg::ST_POOL_CHK: begin
                stk_raddr = IDX_W'(depth_reg - CNT_W'(1));
                if (has_top_reg && top_mean_reg <= cur_mean_reg) begin
                    div_start      = 1'b1;
                    cur_sum_next   = merged_sum;
                    cur_start_next = top_start_reg;
                    if (depth_reg != '0) begin
                        pop_next   = 1'b1;
                        depth_next = depth_reg - CNT_W'(1);
                    end else begin
                        has_top_next = 1'b0;
                    end
                    state_next = slpv_pkg::ST_POOL_DIV;
                end else begin
                    if (has_top_reg) begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + CNT_W'(1);
                    end
                    top_start_next = cur_start_reg;
                    top_sum_next   = cur_sum_reg;
                    top_mean_next  = cur_mean_reg;
                    has_top_next   = 1'b1;
                    if (i_reg + CNT_W'(1) == n_reg) begin
                        state_next = slpv_pkg::ST_POOL_FIN;
                    end else begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = slpv_pkg::ST_POOL_RD;
                    end
                end
            end
            slpv_pkg::ST_POOL_DIV: begin
                if (pop_reg) begin
                    pop_next       = 1'b0;
                    top_start_next = stk_start_rd_reg;
                    top_sum_next   = stk_sum_rd_reg;
                    top_mean_next  = stk_mean_rd_reg;
                end
                if (div_done) begin
                    cur_mean_next = MEAN_W'(div_quot);
                    state_next    = slpv_pkg::ST_POOL_CHK;
                end
            end
            slpv_pkg::ST_POOL_FIN: begin
                stk_we     = 1'b1;
                stk_wend   = IDX_W'(n_reg - CNT_W'(1));
                depth_next = depth_reg + CNT_W'(1);
                b_next     = '0;
                i_next     = '0;
                state_next = slpv_pkg::ST_FILL_HDR;
            end
            // Spread each block value back to load order.
            slpv_pkg::ST_FILL_HDR: begin
                state_next = slpv_pkg::ST_FILL_HDW;
            end
            slpv_pkg::ST_FILL_HDW: begin
                if (!stk_mean_rd_reg[MEAN_W-1] && (|stk_mean_rd_reg)) begin
                    d_next = stk_mean_rd_reg[VB-1:0];
                end else begin
                    d_next = '0;
                end
                end_next   = stk_end_rd_reg;
                state_next = slpv_pkg::ST_FILL_RD;
            end
            slpv_pkg::ST_FILL_RD: begin
                state_next = slpv_pkg::ST_FILL_WR;
            end
            slpv_pkg::ST_FILL_WR: begin
                res_we = 1'b1;
                if (i_reg + CNT_W'(1) == n_reg) begin
                    i_next     = '0;
                    state_next = slpv_pkg::ST_OUT_RD;
                end else begin
                    i_next = i_reg + CNT_W'(1);
                    if (idx == end_reg) begin
                        b_next     = b_reg + CNT_W'(1);
                        state_next = slpv_pkg::ST_FILL_HDR;
                    end else begin
                        state_next = slpv_pkg::ST_FILL_RD;
                    end
                end
            end
            // Emit results in load order.
            slpv_pkg::ST_OUT_RD: begin
                state_next = slpv_pkg::ST_OUT_LD;
            end
            slpv_pkg::ST_OUT_LD: begin
                m_data_next  = out_val;
                m_last_next  = (i_reg + CNT_W'(1) == n_reg);
                m_valid_next = 1'b1;
                state_next   = slpv_pkg::ST_OUT_WAIT;
            end
            slpv_pkg::ST_OUT_WAIT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        cnt_next   = '0;
                        state_next = slpv_pkg::ST_IDLE;
                    end else begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = slpv_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = slpv_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/slpv_chk.sv @@
// Port-level checker for the sorted-L1 proximal vector unit, with its bind.
module slpv_chk #(
    parameter int S_TDATA_W = 64,
    parameter int M_TDATA_W = 32
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);
    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // A closing input transfer starts the computation.
    a_close_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("still ready after the closing transfer");

    // The final result transfer returns the block to loading.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after the final result transfer");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind sorted_l1_prox_vector_unit slpv_chk #(
    .S_TDATA_W (S_TDATA_W),
    .M_TDATA_W (M_TDATA_W)
) u_slpv_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ test/tb_sorted_l1_prox_vector_unit.sv @@
// Testbench for the sorted-L1 proximal vector unit: directed table plus random vectors.
`timescale 1ns / 1ps

module tb_sorted_l1_prox_vector_unit;

    localparam int MAX_LEN = 64;
    localparam int VB = 32;

    // One element as loaded into the unit.
    typedef struct {
        logic signed [VB-1:0] coef;
        logic [VB-2:0]        pen;
        logic                 last;
    } elem_t;

    // One result as emitted by the unit.
    typedef struct {
        logic signed [VB-1:0] prox;
        logic                 last;
    } prox_t;

    // Directed row: an element, and optionally a typed-in result for a one-element vector.
    typedef struct {
        elem_t             e;
        bit                has_exp;
        logic signed [31:0] exp_prox;
    } row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    // Fields from bit 0: coef_value (32), penalty_value (31), zero fill.
    logic [63:0]       s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    // Fields from bit 0: prox_value (32).
    logic [31:0]       m_tdata;
    logic              m_tlast;

    prox_t  prox_queue[$];
    elem_t  vec_buf[$];
    row_t   rows[$];
    int     fail_count;
    bit     src_done;

    sorted_l1_prox_vector_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Compute the proximal results of one closed vector and queue them in load order.
    task automatic predict_prox(input elem_t v[$]);
        int unsigned n;
        logic [VB:0] mag[MAX_LEN];
        int          ord[MAX_LEN];
        int          bstart[MAX_LEN];
        longint      bsum[MAX_LEN];
        longint      bmean[MAX_LEN];
        longint      res[MAX_LEN];
        int          k, key, j;
        longint      s, d, r;
        prox_t       p;
        n = v.size();
        for (int i = 0; i < n; i++) begin
            mag[i] = v[i].coef[VB-1] ? -{v[i].coef[VB-1], v[i].coef} : {1'b0, v[i].coef};
            ord[i] = i;
        end
        // Stable insertion sort, descending magnitude.
        for (int i = 1; i < n; i++) begin
            key = ord[i];
            j = i;
            while (j > 0 && mag[ord[j-1]] < mag[key]) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = key;
        end
        // Pool adjacent violators.
        k = 0;
        for (int i = 0; i < n; i++) begin
            s = longint'(mag[ord[i]]) - longint'(v[i].pen);
            bstart[k] = i;
            bsum[k] = s;
            bmean[k] = s;
            while (k > 0 && bmean[k-1] <= bmean[k]) begin
                k--;
                bsum[k] += bsum[k+1];
                bmean[k] = bsum[k] / longint'(i - bstart[k] + 1);
            end
            k++;
        end
        for (int b = 0; b < k; b++) begin
            d = bmean[b] > 0 ? bmean[b] : 0;
            for (int i = bstart[b]; i < ((b + 1 < k) ? bstart[b+1] : n); i++)
                res[ord[i]] = d;
        end
        // Restore signs in load order.
        for (int i = 0; i < n; i++) begin
            d = res[i];
            if (v[i].coef == 0) r = 0;
            else if (!v[i].coef[VB-1]) r = d;
            else r = -d;
            p.prox = r[VB-1:0];
            p.last = (i + 1 == n);
            prox_queue.push_back(p);
        end
    endtask

    // Record an accepted element and close the vector when it ends.
    task automatic note_elem(input elem_t e);
        vec_buf.push_back(e);
        if (e.last || vec_buf.size() == MAX_LEN) begin
            predict_prox(vec_buf);
            vec_buf.delete();
        end
    endtask

    // Drive one element through the input handshake.
    task automatic send_elem(input elem_t e);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, e.pen, e.coef};
        s_tlast  <= e.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        note_elem(e);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic row_t mk_row(input logic [31:0] c, input logic [30:0] p, input logic l,
                                    input bit he, input logic [31:0] x);
        row_t r;
        r.e.coef = c;
        r.e.pen = p;
        r.e.last = l;
        r.has_exp = he;
        r.exp_prox = x;
        return r;
    endfunction

    // Check results against the oldest expectation.
    always @(posedge aclk) begin
        prox_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (prox_queue.size() == 0) begin
                $display("%0t: unexpected result prox=%h last=%b", $time, m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = prox_queue.pop_front();
                if (m_tdata !== want.prox || m_tlast !== want.last) begin
                    $display("%0t: expected prox=%h last=%b, actual prox=%h last=%b",
                             $time, want.prox, want.last, m_tdata, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Random backpressure on the result side.
    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!aresetn) m_tready <= 1'b1;
        else if (r < 3) m_tready <= 1'b0;
        else if (r < 20) m_tready <= ~m_tready;
        else if (r < 60) m_tready <= 1'b1;
    end

    // Main stimulus.
    initial begin
        elem_t e;
        int    len, kind;
        logic [30:0] p;
        fail_count = 0;
        src_done = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; single-element vectors with obvious results carry them.
        rows.push_back(mk_row(32'h0001_0000, 31'h0, 1'b1, 1, 32'h0001_0000));
        rows.push_back(mk_row(32'h0, 31'h7fff_ffff, 1'b1, 1, 32'h0));
        rows.push_back(mk_row(32'h7fff_ffff, 31'h0, 1'b1, 1, 32'h7fff_ffff));
        rows.push_back(mk_row(32'h8000_0000, 31'h0, 1'b1, 1, 32'h8000_0000));
        rows.push_back(mk_row(32'h8000_0000, 31'h7fff_ffff, 1'b1, 1, 32'hffff_ffff));
        rows.push_back(mk_row(32'hffff_ffff, 31'h7fff_ffff, 1'b1, 1, 32'h0));
        rows.push_back(mk_row(32'h0003_0000, 31'h0001_0000, 1'b1, 1, 32'h0002_0000));
        // Ties in magnitude with opposite signs, and out-of-order lambdas.
        rows.push_back(mk_row(32'h0002_0000, 31'h0000_8000, 1'b0, 0, 0));
        rows.push_back(mk_row(32'hfffe_0000, 31'h0001_0000, 1'b0, 0, 0));
        rows.push_back(mk_row(32'h0, 31'h0, 1'b0, 0, 0));
        rows.push_back(mk_row(32'h0005_0001, 31'h0000_0001, 1'b1, 0, 0));
        rows.push_back(mk_row(32'h7fff_ffff, 31'h7fff_ffff, 1'b0, 0, 0));
        rows.push_back(mk_row(32'h8000_0000, 31'h5555_5555, 1'b0, 0, 0));
        rows.push_back(mk_row(32'h1234_5678, 31'h2aaa_aaaa, 1'b1, 0, 0));
        foreach (rows[i]) begin
            send_elem(rows[i].e);
            if (rows[i].has_exp) prox_queue[prox_queue.size()-1].prox = rows[i].exp_prox;
            idle_gap();
        end

        // Full buffer without tlast: 64 elements close the vector on their own.
        p = 31'h7fff_ffff;
        for (int i = 0; i < MAX_LEN; i++) begin
            e.coef = $urandom;
            p = p - 31'($urandom_range(0, 1 << 24));
            e.pen = p;
            e.last = 1'b0;
            send_elem(e);
        end

        // Let everything drain once before the random part.
        s_tvalid <= 1'b0;
        while (prox_queue.size() != 0) @(posedge aclk);

        // Random vectors, mostly short and well formed with nonincreasing lambdas.
        for (int v = 0; v < 5; v++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            kind = $urandom_range(0, 9);
            p = $urandom_range(0, 3) == 0 ? 31'h7fff_ffff
                                          : 31'($urandom_range(0, 32'h0008_0000));
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 5))
                    0: e.coef = $urandom;
                    1: e.coef = 32'h0;
                    2: e.coef = 32'h8000_0000;
                    default: e.coef = $signed($urandom_range(0, 32'h000a_0000)) - 32'sh0005_0000;
                endcase
                if (kind == 0) p = 31'($urandom);
                else p = p - 31'($urandom_range(0, p < 31'h0001_0000 ? p : 31'h0001_0000));
                e.pen = p;
                e.last = (i + 1 == len);
                send_elem(e);
                idle_gap();
            end
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        src_done = 1;
    end

    // End of run.
    initial begin
        wait (src_done);
        while (prox_queue.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && prox_queue.size() == 0 && vec_buf.size() == 0)
            $display("sorted_l1_prox_vector_unit: match");
        else
            $display("sorted_l1_prox_vector_unit: mismatch");
        $finish;
    end

    // Timeout.
    initial begin
        #20ms;
        $display("sorted_l1_prox_vector_unit: mismatch");
        $finish;
    end

endmodule
